// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for checker modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define CHK_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: implication violated");

// next-cycle implication, held off during reset
`define CHK_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: next-cycle implication violated");

`endif

// File: rtl/core/afps_pkg.sv
// ----------------------------------------------------------------------------
// afps_pkg
// Types, constants and codes of the feedback packet sizer.
// ----------------------------------------------------------------------------
package afps_pkg;

	localparam int RING_DEPTH_DEF = 128;
	localparam int PATTERN_LEN    = 8;
	localparam int PAT_W          = $clog2(PATTERN_LEN);
	localparam int WARMUP_FILL    = 80;
	localparam int OVERRUN_MARGIN = 16;
	localparam int FRAME_BYTES    = 12;
	localparam int ACC_W          = 12;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;

	localparam logic [CFG_IDX_W-1:0] REG_BASE    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FB_LOW  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FB_HIGH = 2'd2;

	localparam logic [4:0] BASE_RST    = 5'd6;
	localparam logic [7:0] FB_LOW_RST  = 8'd46;
	localparam logic [7:0] FB_HIGH_RST = 8'd50;

	localparam logic [1:0] OP_FEEDBACK = 2'd0;
	localparam logic [1:0] OP_FAIL     = 2'd1;
	localparam logic [1:0] OP_PLAY     = 2'd2;

	typedef struct packed {
		logic [1:0] operation;
		logic [7:0] fb_value;
		logic       packet_ok;
		logic       last_in_transfer;
	} in_t;

	typedef struct packed {
		logic [7:0]  frame_count;
		logic [11:0] packet_bytes;
		logic        synced;
		logic        warmed_up;
		logic [6:0]  ring_level;
		logic [7:0]  last_feedback;
		logic [15:0] overrun_total;
		logic [15:0] underrun_total;
	} out_t;

	typedef struct packed {
		logic load;
		logic decode;
		logic push;
		logic take;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic       push_ok;
		logic       pop_ok;
		logic       push_last;
	} sts_t;

endpackage

// File: rtl/core/afps_ram.sv
// ----------------------------------------------------------------------------
// afps_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module afps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/core/afps_ctrl.sv
// ----------------------------------------------------------------------------
// afps_ctrl
// Sequencer of the packet sizer: decode, pattern push, ring read, report.
// ----------------------------------------------------------------------------
module afps_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  afps_pkg::sts_t sts,
	output afps_pkg::cmd_t cmd,
	output logic          busy,
	output logic          done
);

	import afps_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_PUSH,
		ST_READ,
		ST_FINISH
	} state_t;

	state_t state_q;
	logic   done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= (state_q == ST_FINISH);
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_DECODE;
					end
				end
				ST_DECODE: begin
					if (sts.op == OP_FEEDBACK && sts.push_ok) begin
						state_q <= ST_PUSH;
					end else if (sts.op == OP_PLAY && sts.pop_ok) begin
						state_q <= ST_READ;
					end else begin
						state_q <= ST_FINISH;
					end
				end
				ST_PUSH: begin
					if (sts.push_last) begin
						state_q <= ST_FINISH;
					end
				end
				ST_READ: begin
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		cmd        = '0;
		cmd.load   = (state_q == ST_IDLE) && start;
		cmd.decode = (state_q == ST_DECODE);
		cmd.push   = (state_q == ST_PUSH);
		cmd.take   = (state_q == ST_READ);
		cmd.finish = (state_q == ST_FINISH);
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;

endmodule

// File: rtl/core/afps_dp.sv
// ----------------------------------------------------------------------------
// afps_dp
// Datapath of the packet sizer: configuration, ring indexes, pattern
// generator, flags, counters and result registers.
// ----------------------------------------------------------------------------
module afps_dp #(
	parameter int RING_DEPTH = afps_pkg::RING_DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  afps_pkg::cmd_t                   cmd,
	output afps_pkg::sts_t                   sts,
	input  afps_pkg::in_t                    item,
	input  logic                             wr_en,
	input  logic [afps_pkg::CFG_IDX_W-1:0]   wr_index,
	input  logic [afps_pkg::CFG_DATA_W-1:0]  wr_data,
	output afps_pkg::out_t                   result
);

	import afps_pkg::*;

	localparam int AW        = $clog2(RING_DEPTH);
	localparam int OVR_LIMIT = RING_DEPTH - OVERRUN_MARGIN;
	localparam logic [AW:0] DEPTH_W = (AW+1)'(RING_DEPTH);

	logic [4:0]       base_q;
	logic [7:0]       fb_low_q;
	logic [7:0]       fb_high_q;

	in_t              item_q;
	logic [AW-1:0]    wr_q;
	logic [AW-1:0]    rd_q;
	logic             sync_q;
	logic             warm_q;
	logic             lost_q;
	logic [7:0]       lastfb_q;
	logic [15:0]      ovr_q;
	logic [15:0]      und_q;
	logic [7:0]       frames_q;
	logic [11:0]      bytes_q;
	logic [7:0]       amount_q;
	logic             neg_q;
	logic [ACC_W-1:0] acc_q;
	logic [PAT_W-1:0] cnt_q;

	logic [AW:0]      fill_ext;
	logic [AW-1:0]    fill;
	logic             empty;
	logic             in_win;
	logic [9:0]       diff;
	logic [ACC_W-1:0] acc_sum;
	logic             adj;
	logic [7:0]       count;
	logic [AW:0]      waddr_sum;
	logic [AW-1:0]    waddr;
	logic [AW:0]      wr_adv;
	logic             ram_re;
	logic [7:0]       ram_rdata;

	assign fill_ext = (wr_q >= rd_q) ? ({1'b0, wr_q} - {1'b0, rd_q})
		: ({1'b0, wr_q} + DEPTH_W - {1'b0, rd_q});
	assign fill   = fill_ext[AW-1:0];
	assign empty  = (wr_q == rd_q);
	assign in_win = (item_q.fb_value >= fb_low_q) && (item_q.fb_value <= fb_high_q);
	assign diff   = {2'b00, item_q.fb_value} - {2'b00, base_q, 3'b000};

	assign acc_sum = acc_q + ACC_W'(amount_q);
	assign adj     = (acc_sum >= ACC_W'(PATTERN_LEN));
	assign count   = !adj ? {3'b000, base_q}
		: (neg_q ? ({3'b000, base_q} - 8'd1) : ({3'b000, base_q} + 8'd1));

	assign waddr_sum = {1'b0, wr_q} + (AW+1)'(cnt_q);
	assign waddr     = (waddr_sum >= DEPTH_W) ? AW'(waddr_sum - DEPTH_W) : waddr_sum[AW-1:0];
	assign wr_adv    = {1'b0, wr_q} + (AW+1)'(PATTERN_LEN);

	assign ram_re = cmd.decode && (item_q.operation == OP_PLAY) && warm_q && !empty;

	afps_ram #(
		.WIDTH (8),
		.DEPTH (RING_DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (cmd.push),
		.waddr (waddr),
		.wdata (count),
		.re    (ram_re),
		.raddr (rd_q),
		.rdata (ram_rdata)
	);

	always_comb begin
		sts           = '0;
		sts.op        = item_q.operation;
		sts.push_ok   = item_q.packet_ok && in_win;
		sts.pop_ok    = warm_q && !empty;
		sts.push_last = (cnt_q == PAT_W'(PATTERN_LEN - 1));
	end

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q    <= BASE_RST;
			fb_low_q  <= FB_LOW_RST;
			fb_high_q <= FB_HIGH_RST;
		end else if (wr_en) begin
			case (wr_index)
				REG_BASE:    base_q    <= wr_data[4:0];
				REG_FB_LOW:  fb_low_q  <= wr_data;
				REG_FB_HIGH: fb_high_q <= wr_data;
				default: begin
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= item;
		end
		if (cmd.decode) begin
			acc_q    <= '0;
			neg_q    <= diff[9] || (diff == 10'd0);
			amount_q <= diff[9] ? 8'(-diff) : diff[7:0];
			frames_q <= (item_q.operation == OP_PLAY && !(warm_q && !empty))
				? {3'b000, base_q} : '0;
		end
		if (cmd.push) begin
			acc_q <= adj ? (acc_sum - ACC_W'(PATTERN_LEN)) : acc_sum;
		end
		if (cmd.take) begin
			frames_q <= ram_rdata;
		end
		if (cmd.finish) begin
			bytes_q <= 12'({4'b0000, frames_q} * 12'(FRAME_BYTES));
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q     <= '0;
			rd_q     <= '0;
			sync_q   <= 1'b0;
			warm_q   <= 1'b0;
			lost_q   <= 1'b0;
			lastfb_q <= '0;
			ovr_q    <= '0;
			und_q    <= '0;
			cnt_q    <= '0;
		end else begin
			if (cmd.decode) begin
				cnt_q <= '0;
				case (item_q.operation)
					OP_FEEDBACK: begin
						if (item_q.packet_ok) begin
							lastfb_q <= item_q.fb_value;
							if (in_win) begin
								if (int'(fill) > OVR_LIMIT && ovr_q != 16'hFFFF) begin
									ovr_q <= ovr_q + 16'd1;
								end
							end else begin
								lost_q <= 1'b1;
							end
						end else begin
							lost_q <= 1'b1;
						end
					end
					OP_FAIL: begin
						sync_q <= 1'b0;
						warm_q <= 1'b0;
						lost_q <= 1'b0;
					end
					OP_PLAY: begin
						if (warm_q && empty && und_q != 16'hFFFF) begin
							und_q <= und_q + 16'd1;
						end
					end
					default: begin
					end
				endcase
			end
			if (cmd.push) begin
				cnt_q <= cnt_q + PAT_W'(1);
				if (sts.push_last) begin
					wr_q <= (wr_adv >= DEPTH_W) ? AW'(wr_adv - DEPTH_W) : wr_adv[AW-1:0];
				end
			end
			if (cmd.take) begin
				rd_q <= (rd_q == AW'(RING_DEPTH - 1)) ? '0 : rd_q + AW'(1);
			end
			if (cmd.finish && item_q.operation == OP_FEEDBACK && item_q.last_in_transfer) begin
				if (lost_q) begin
					sync_q <= 1'b0;
					warm_q <= 1'b0;
				end else begin
					sync_q <= 1'b1;
					if (int'(fill) >= WARMUP_FILL) begin
						warm_q <= 1'b1;
					end
				end
				lost_q <= 1'b0;
			end
		end
	end

	always_comb begin
		result                = '0;
		result.frame_count    = frames_q;
		result.packet_bytes   = bytes_q;
		result.synced         = sync_q;
		result.warmed_up      = warm_q;
		result.ring_level     = 7'(fill);
		result.last_feedback  = lastfb_q;
		result.overrun_total  = ovr_q;
		result.underrun_total = und_q;
	end

endmodule

// File: rtl/core/audio_feedback_packet_sizer.sv
// ----------------------------------------------------------------------------
// audio_feedback_packet_sizer
// Spreads feedback values into per-microframe frame counts held in a ring
// and sizes playback packets from it.
// ----------------------------------------------------------------------------
// channel   ports                      transfer
// input     start, busy, item          start high while busy low
// result    done, result               done high for one cycle, no stall
// config    wr_en, wr_index, wr_data   write when wr_en high
//
// A feedback packet pushed into the ring passes decode, 8 ring writes
// through the single RAM write port, and finish while busy.
// A playback slot popping the ring passes decode, RAM read and finish.
// Other items pass decode and finish. The result shows in the cycle in which busy
// drops; a new item may start in that same cycle. Reset is asynchronous;
// the ring needs no clearing pass and the block is ready right after reset.
// ----------------------------------------------------------------------------
module audio_feedback_packet_sizer #(
	parameter int RING_DEPTH = afps_pkg::RING_DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  afps_pkg::in_t                    item,
	output logic                             done,
	output afps_pkg::out_t                   result,
	input  logic                             wr_en,
	input  logic [afps_pkg::CFG_IDX_W-1:0]   wr_index,
	input  logic [afps_pkg::CFG_DATA_W-1:0]  wr_data
);

	import afps_pkg::*;

	cmd_t cmd;
	sts_t sts;

	afps_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	afps_dp #(
		.RING_DEPTH (RING_DEPTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.item     (item),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.result   (result)
	);

endmodule

// File: rtl/core/afps_chk.sv
// ----------------------------------------------------------------------------
// afps_chk
// Port-level checks of the packet sizer, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module afps_chk (
	input logic           clk,
	input logic           arst_n,
	input logic           start,
	input logic           busy,
	input logic           done,
	input afps_pkg::out_t result
);

	`CHK_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy)
	`CHK_IMPLY(a_busy_from_start, clk, arst_n, $rose(busy), $past(start))
	`CHK_IMPLY(a_done_idle, clk, arst_n, done, !busy)
	`CHK_NEXT(a_done_single, clk, arst_n, done, !done)
	`CHK_IMPLY(a_warm_needs_sync, clk, arst_n, done && result.warmed_up, result.synced)

endmodule

bind audio_feedback_packet_sizer afps_chk u_chk (.*);

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the feedback packet sizer. A short table of
// directed words (extremes, all operations, lost packets, warm-up) runs
// first, then random feedback transfers and playback slots under seven
// register settings. Every result is checked field by field against a
// typed table row or a behavioral predictor of the ring, sync and warm-up state.
// ----------------------------------------------------------------------------
module tb;
	import afps_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int WATCHDOG_LIMIT = 2000;

	typedef struct packed {
		in_t  word;
		logic typed;
		out_t want;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	in_t item;
	logic done;
	out_t result;
	logic wr_en;
	logic [CFG_IDX_W-1:0] wr_index;
	logic [CFG_DATA_W-1:0] wr_data;

	// predictor state
	logic [7:0] frame_ring [RING_DEPTH_DEF];
	logic [6:0] wr_ptr, rd_ptr;
	logic sync_m, warm_m, lost_m;
	logic [7:0] last_fb_m;
	logic [15:0] ovr_cnt, und_cnt;
	logic [4:0] base_m;
	logic [7:0] fb_lo, fb_hi;

	out_t sizes_due [$];
	dir_row_t dir_rows [$];
	out_t head;
	int errors, checked, items_sent, warm_rises, idle_pct, quiet_cycles;

	audio_feedback_packet_sizer dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.done(done),
		.result(result),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data)
	);

	always #1 clk = ~clk;

	function automatic logic [6:0] ring_fill();
		return wr_ptr - rd_ptr;
	endfunction

	function automatic out_t size_packet(in_t w);
		out_t r;
		logic [7:0] frames;
		logic [6:0] slot;
		int adj, amount, acc, dir, cnt;
		frames = '0;
		case (w.operation)
		OP_FEEDBACK: begin
			if (w.packet_ok) begin
				last_fb_m = w.fb_value;
				if (w.fb_value >= fb_lo && w.fb_value <= fb_hi) begin
					if (ring_fill() > RING_DEPTH_DEF - OVERRUN_MARGIN && ovr_cnt != 16'hFFFF)
						ovr_cnt++;
					adj = int'(w.fb_value) - PATTERN_LEN * int'(base_m);
					dir = adj > 0 ? 1 : -1;
					amount = adj < 0 ? -adj : adj;
					acc = 0;
					for (int i = 0; i < PATTERN_LEN; i++) begin
						cnt = int'(base_m);
						acc += amount;
						if (acc >= PATTERN_LEN) begin
							cnt = cnt + dir;
							acc -= PATTERN_LEN;
						end
						slot = wr_ptr + 7'(i);
						frame_ring[slot] = 8'(cnt);
					end
					wr_ptr = wr_ptr + 7'(PATTERN_LEN);
				end else begin
					lost_m = 1'b1;
				end
			end else begin
				lost_m = 1'b1;
			end
			if (w.last_in_transfer) begin
				if (lost_m) begin
					sync_m = 1'b0;
					warm_m = 1'b0;
				end else begin
					sync_m = 1'b1;
					if (!warm_m && ring_fill() >= WARMUP_FILL) begin
						warm_m = 1'b1;
						warm_rises++;
					end
				end
				lost_m = 1'b0;
			end
		end
		OP_FAIL: begin
			sync_m = 1'b0;
			warm_m = 1'b0;
			lost_m = 1'b0;
		end
		OP_PLAY: begin
			if (!warm_m || wr_ptr == rd_ptr) begin
				if (warm_m && und_cnt != 16'hFFFF)
					und_cnt++;
				frames = {3'b000, base_m};
			end else begin
				frames = frame_ring[rd_ptr];
				rd_ptr = rd_ptr + 7'd1;
			end
		end
		default: begin
		end
		endcase
		r.frame_count = frames;
		r.packet_bytes = 12'(int'(frames) * FRAME_BYTES);
		r.synced = sync_m;
		r.warmed_up = warm_m;
		r.ring_level = ring_fill();
		r.last_feedback = last_fb_m;
		r.overrun_total = ovr_cnt;
		r.underrun_total = und_cnt;
		return r;
	endfunction

	function automatic void check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			errors++;
			if (errors <= 40)
				$display("%0t: %s expected %0d got %0d", $time, name, want, got);
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (sizes_due.size() == 0) begin
				errors++;
				if (errors <= 40)
					$display("%0t: result expected none got %h", $time, result);
			end else begin
				head = sizes_due.pop_front();
				checked++;
				check_field("frame_count", head.frame_count, result.frame_count);
				check_field("packet_bytes", head.packet_bytes, result.packet_bytes);
				check_field("synced", head.synced, result.synced);
				check_field("warmed_up", head.warmed_up, result.warmed_up);
				check_field("ring_level", head.ring_level, result.ring_level);
				check_field("last_feedback", head.last_feedback, result.last_feedback);
				check_field("overrun_total", head.overrun_total, result.overrun_total);
				check_field("underrun_total", head.underrun_total, result.underrun_total);
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done || wr_en)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no word moved for %0d cycles, %0d results outstanding", $time,
				WATCHDOG_LIMIT, sizes_due.size());
			$display("audio_feedback_packet_sizer test failed");
			$finish;
		end
	end

	task automatic settle(int tail);
		start <= 1'b0;
		@(posedge clk);
		while (sizes_due.size() != 0)
			@(posedge clk);
		repeat (tail) @(posedge clk);
	endtask

	task automatic send(in_t w, logic typed, out_t want);
		int gap;
		gap = 0;
		if ($urandom_range(0, 99) < idle_pct)
			gap = $urandom_range(1, 12);
		if (items_sent % 97 == 50) begin
			settle(0);
		end else if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		item <= w;
		do @(posedge clk); while (busy);
		items_sent++;
		head = size_packet(w);
		sizes_due.push_back(typed ? want : head);
	endtask

	task automatic set_regs(logic [4:0] b, logic [7:0] lo, logic [7:0] hi);
		settle(4);
		wr_en <= 1'b1;
		wr_index <= REG_BASE;
		wr_data <= {3'($urandom), b};
		@(posedge clk);
		base_m = b;
		wr_index <= REG_FB_LOW;
		wr_data <= lo;
		@(posedge clk);
		fb_lo = lo;
		wr_index <= REG_FB_HIGH;
		wr_data <= hi;
		@(posedge clk);
		fb_hi = hi;
		wr_en <= 1'b0;
	endtask

	task automatic run_random(int n, int pct);
		int sent, kind, len, plays, thr;
		logic draining;
		in_t w;
		sent = 0;
		draining = 1'b0;
		thr = $urandom_range(96, 127);
		idle_pct = pct;
		while (sent < n) begin
			w.fb_value = 8'($urandom);
			w.packet_ok = 1'($urandom);
			w.last_in_transfer = 1'($urandom);
			kind = $urandom_range(0, 99);
			if (kind < 3) begin
				w.operation = OP_FAIL;
				send(w, 1'b0, '0);
				sent++;
			end else if (kind < 5) begin
				w.operation = OP_UNUSED;
				send(w, 1'b0, '0);
				sent++;
			end else if (kind < 9) begin
				w.operation = OP_FEEDBACK;
				send(w, 1'b0, '0);
				sent++;
			end else begin
				len = $urandom_range(1, 4);
				for (int k = 0; k < len; k++) begin
					w.operation = OP_FEEDBACK;
					if (fb_lo <= fb_hi && $urandom_range(0, 24) != 0)
						w.fb_value = 8'($urandom_range(int'(fb_hi), int'(fb_lo)));
					else
						w.fb_value = 8'($urandom);
					w.packet_ok = ($urandom_range(0, 49) != 0);
					w.last_in_transfer = (k == len - 1);
					send(w, 1'b0, '0);
					sent++;
					if (!draining && ring_fill() >= thr)
						draining = 1'b1;
					plays = $urandom_range(0, draining ? 40 : 6);
					repeat (plays) begin
						w.operation = OP_PLAY;
						w.fb_value = 8'($urandom);
						w.packet_ok = 1'($urandom);
						w.last_in_transfer = 1'($urandom);
						send(w, 1'b0, '0);
						sent++;
						if (draining && ring_fill() == 0) begin
							draining = 1'b0;
							thr = $urandom_range(96, 127);
						end
					end
				end
			end
		end
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		wr_en = 1'b0;
		wr_index = '0;
		wr_data = '0;
		errors = 0;
		checked = 0;
		items_sent = 0;
		warm_rises = 0;
		idle_pct = 0;
		quiet_cycles = 0;
		wr_ptr = '0;
		rd_ptr = '0;
		sync_m = 1'b0;
		warm_m = 1'b0;
		lost_m = 1'b0;
		last_fb_m = '0;
		ovr_cnt = '0;
		und_cnt = '0;
		base_m = BASE_RST;
		fb_lo = FB_LOW_RST;
		fb_hi = FB_HIGH_RST;

		dir_rows.push_back({{OP_PLAY, 8'd0, 1'b0, 1'b0}, 1'b1,
			{8'd6, 12'd72, 1'b0, 1'b0, 7'd0, 8'd0, 16'd0, 16'd0}});
		dir_rows.push_back({{OP_UNUSED, 8'd255, 1'b1, 1'b1}, 1'b1,
			{8'd0, 12'd0, 1'b0, 1'b0, 7'd0, 8'd0, 16'd0, 16'd0}});
		dir_rows.push_back({{OP_FEEDBACK, 8'd48, 1'b1, 1'b1}, 1'b1,
			{8'd0, 12'd0, 1'b1, 1'b0, 7'd8, 8'd48, 16'd0, 16'd0}});
		dir_rows.push_back({{OP_FEEDBACK, 8'd255, 1'b1, 1'b0}, 1'b1,
			{8'd0, 12'd0, 1'b1, 1'b0, 7'd8, 8'd255, 16'd0, 16'd0}});
		dir_rows.push_back({{OP_FEEDBACK, 8'd0, 1'b0, 1'b1}, 1'b1,
			{8'd0, 12'd0, 1'b0, 1'b0, 7'd8, 8'd255, 16'd0, 16'd0}});
		dir_rows.push_back({{OP_FAIL, 8'd255, 1'b1, 1'b1}, 1'b1,
			{8'd0, 12'd0, 1'b0, 1'b0, 7'd8, 8'd255, 16'd0, 16'd0}});
		dir_rows.push_back({{OP_FEEDBACK, 8'd46, 1'b1, 1'b0}, 1'b0, 69'd0});
		dir_rows.push_back({{OP_FEEDBACK, 8'd50, 1'b1, 1'b1}, 1'b0, 69'd0});
		dir_rows.push_back({{OP_FEEDBACK, 8'd0, 1'b1, 1'b1}, 1'b0, 69'd0});
		dir_rows.push_back({{OP_FEEDBACK, 8'd47, 1'b1, 1'b0}, 1'b0, 69'd0});
		dir_rows.push_back({{OP_FEEDBACK, 8'd49, 1'b1, 1'b0}, 1'b0, 69'd0});
		dir_rows.push_back({{OP_FEEDBACK, 8'd48, 1'b1, 1'b0}, 1'b0, 69'd0});
		dir_rows.push_back({{OP_FEEDBACK, 8'd48, 1'b1, 1'b0}, 1'b0, 69'd0});
		dir_rows.push_back({{OP_FEEDBACK, 8'd46, 1'b1, 1'b0}, 1'b0, 69'd0});
		dir_rows.push_back({{OP_FEEDBACK, 8'd50, 1'b1, 1'b0}, 1'b0, 69'd0});
		dir_rows.push_back({{OP_FEEDBACK, 8'd49, 1'b1, 1'b1}, 1'b0, 69'd0});
		dir_rows.push_back({{OP_PLAY, 8'd255, 1'b1, 1'b1}, 1'b0, 69'd0});
		dir_rows.push_back({{OP_PLAY, 8'd0, 1'b0, 1'b0}, 1'b0, 69'd0});
		dir_rows.push_back({{OP_PLAY, 8'd170, 1'b1, 1'b0}, 1'b0, 69'd0});
		dir_rows.push_back({{OP_FAIL, 8'd0, 1'b0, 1'b0}, 1'b0, 69'd0});
		dir_rows.push_back({{OP_PLAY, 8'd85, 1'b0, 1'b1}, 1'b0, 69'd0});

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			send(dir_rows[i].word, dir_rows[i].typed, dir_rows[i].want);
		run_random(118, 0);
		set_regs(5'd1, 8'd0, 8'd255);
		run_random(118, 49);
		set_regs(5'd24, 8'd180, 8'd200);
		run_random(118, 0);
		set_regs(5'd31, 8'd240, 8'd255);
		run_random(118, 37);
		// zero base: adjustments only upward
		set_regs(5'd0, 8'd0, 8'd20);
		run_random(118, 0);
		// empty window: low above high
		set_regs(5'd12, 8'd200, 8'd100);
		run_random(118, 49);
		set_regs(5'd6, 8'd40, 8'd56);
		run_random(118, 37);

		settle(12);
		$display("covered %0d words over 7 register settings, %0d results checked", items_sent,
			checked);
		$display("warm-up reached %0d times, overruns %0d, underruns %0d", warm_rises, ovr_cnt,
			und_cnt);
		if (errors == 0)
			$display("audio_feedback_packet_sizer test passed");
		else
			$display("audio_feedback_packet_sizer test failed");
		$finish;
	end

endmodule

// File: audio_feedback_packet_sizer.f
+incdir+rtl/core
rtl/core/afps_pkg.sv
rtl/core/afps_ram.sv
rtl/core/afps_ctrl.sv
rtl/core/afps_dp.sv
rtl/core/audio_feedback_packet_sizer.sv
rtl/core/afps_chk.sv
tb/sv/tb.sv
